FILE: hdl/qtrm_pkg.sv
// Shared types, widths and helpers for the quaternion to rotation matrix block.
package qtrm_pkg;

  localparam int CW = 16;            // component width
  localparam int FB = 14;            // fraction bits
  localparam int PW = 2 * CW;        // product width (signed)
  localparam int NW = 2 * CW + 1;    // norm width (unsigned)
  localparam int MW = 2 * CW + 2;    // numerator width (signed)
  localparam int QW = FB + 1;        // quotient width
  localparam int LANES = 9;
  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);

  typedef struct packed {
    logic signed [CW-1:0] quat_w;
    logic signed [CW-1:0] quat_x;
    logic signed [CW-1:0] quat_y;
    logic signed [CW-1:0] quat_z;
  } qtrm_in_t;

  typedef struct packed {
    logic signed [CW-1:0] r0c0;
    logic signed [CW-1:0] r1c0;
    logic signed [CW-1:0] r2c0;
    logic signed [CW-1:0] r0c1;
    logic signed [CW-1:0] r1c1;
    logic signed [CW-1:0] r2c1;
    logic signed [CW-1:0] r0c2;
    logic signed [CW-1:0] r1c2;
    logic signed [CW-1:0] r2c2;
    logic                 zero_norm;
  } qtrm_out_t;

  // one job between front and back: nine numerators and the shared divisor
  typedef struct packed {
    logic [LANES-1:0][MW-1:0] num;
    logic [NW-1:0]            n;
    logic                     zero;
  } qtrm_job_t;

  function automatic logic signed [MW-1:0] sx(input logic signed [PW-1:0] p);
    sx = MW'(p);
  endfunction

endpackage

FILE: hdl/quaternion_to_rotation_matrix.sv
// Top level: quaternion in, 3x3 rotation matrix out, Q1.14.
//
//  channel | valid     | stall     | payload
//  in      | in_valid  | in_stall  | in_data  (quat_w, quat_x, quat_y, quat_z)
//  out     | out_valid | out_stall | out_data (r0c0..r2c2, zero_norm)
//
// One beat per cycle sustained while out_stall is low; a beat passes the front stages, the queue,
// 15 divider stages (one quotient bit each) and the output register.
// Reset (rst, synchronous) empties every stage and the four-entry queue.
// A stall at the output freezes the divider pipe; the front keeps taking beats
// until the queue fills, then raises in_stall.
module quaternion_to_rotation_matrix (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  qtrm_pkg::qtrm_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output qtrm_pkg::qtrm_out_t out_data
);
  import qtrm_pkg::*;

  logic      f_valid, q_full, q_empty, q_pop;
  qtrm_job_t f_job, q_job;

  qtrm_front u_front (
    .clk, .rst, .in_valid, .in_stall, .in_data,
    .job_valid(f_valid), .job_full(q_full), .job(f_job)
  );

  qtrm_fifo u_fifo (
    .clk, .rst, .push(f_valid), .wdata(f_job), .pop(q_pop),
    .rdata(q_job), .full(q_full), .empty(q_empty)
  );

  qtrm_back u_back (
    .clk, .rst, .job_empty(q_empty), .job_pop(q_pop), .job(q_job),
    .out_valid, .out_stall, .out_data
  );

endmodule

FILE: hdl/qtrm_front.sv
// Front end: products, norm and the nine signed numerators, two stages.
module qtrm_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  qtrm_pkg::qtrm_in_t  in_data,
  output logic                job_valid,
  input  logic                job_full,
  output qtrm_pkg::qtrm_job_t job
);
  import qtrm_pkg::*;

  logic f1v, f2v, adv;
  logic signed [PW-1:0] ww, xx, yy, zz, wx, wy, wz, xy, xz, yz;
  logic signed [MW-1:0] nsum;
  logic [LANES-1:0][MW-1:0] num_next;

  assign adv       = !f2v || !job_full;
  assign in_stall  = !adv;
  assign job_valid = f2v;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1v <= 1'b0;
      f2v <= 1'b0;
    end else if (adv) begin
      f1v <= in_valid;
      f2v <= f1v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ww <= in_data.quat_w * in_data.quat_w;
      xx <= in_data.quat_x * in_data.quat_x;
      yy <= in_data.quat_y * in_data.quat_y;
      zz <= in_data.quat_z * in_data.quat_z;
      wx <= in_data.quat_w * in_data.quat_x;
      wy <= in_data.quat_w * in_data.quat_y;
      wz <= in_data.quat_w * in_data.quat_z;
      xy <= in_data.quat_x * in_data.quat_y;
      xz <= in_data.quat_x * in_data.quat_z;
      yz <= in_data.quat_y * in_data.quat_z;
    end
  end

  always_comb begin
    nsum = sx(ww) + sx(xx) + sx(yy) + sx(zz);
    num_next[0] = nsum - ((sx(yy) + sx(zz)) <<< 1);
    num_next[1] = (sx(xy) + sx(wz)) <<< 1;
    num_next[2] = (sx(xz) - sx(wy)) <<< 1;
    num_next[3] = (sx(xy) - sx(wz)) <<< 1;
    num_next[4] = nsum - ((sx(xx) + sx(zz)) <<< 1);
    num_next[5] = (sx(yz) + sx(wx)) <<< 1;
    num_next[6] = (sx(xz) + sx(wy)) <<< 1;
    num_next[7] = (sx(yz) - sx(wx)) <<< 1;
    num_next[8] = nsum - ((sx(xx) + sx(yy)) <<< 1);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      job.num  <= num_next;
      job.n    <= nsum[NW-1:0];
      job.zero <= (nsum == '0);
    end
  end

endmodule

FILE: hdl/qtrm_fifo.sv
// Short job queue between front and back.
module qtrm_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  qtrm_pkg::qtrm_job_t wdata,
  input  logic                pop,
  output qtrm_pkg::qtrm_job_t rdata,
  output logic                full,
  output logic                empty
);
  import qtrm_pkg::*;

  qtrm_job_t         mem [0:QDEPTH-1];
  logic [QAW-1:0]    wp, rp;
  logic [QAW:0]      count;
  logic              do_push, do_pop;

  assign full    = (count == (QAW+1)'(QDEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rp];

  always_ff @(posedge clk) begin
    if (do_push) mem[wp] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (do_push) wp <= wp + 1'b1;
      if (do_pop)  rp <= rp + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= (QAW+1)'(QDEPTH)) else $error("queue over-filled");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> count == $past(count) + 1'b1)
    else $error("queue count lost a push");
  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (do_pop && !do_push) |=> count == $past(count) - 1'b1)
    else $error("queue count lost a pop");

endmodule

FILE: hdl/qtrm_back.sv
// Back end: nine lanes of pipelined restoring division, then saturation.
module qtrm_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 job_empty,
  output logic                 job_pop,
  input  qtrm_pkg::qtrm_job_t  job,
  output logic                 out_valid,
  input  logic                 out_stall,
  output qtrm_pkg::qtrm_out_t  out_data
);
  import qtrm_pkg::*;

  localparam int SW = QW + CW;
  localparam logic [SW-1:0] MAXPOS = SW'((1 << (CW-1)) - 1);
  localparam logic [SW-1:0] MAXNEG = SW'(1 << (CW-1));

  logic              adv;
  logic              v   [0:FB];
  logic              zf  [0:FB];
  logic [NW-1:0]     dn  [0:FB];
  logic [NW-1:0]     rem [0:FB][0:LANES-1];
  logic [QW-1:0]     quo [0:FB][0:LANES-1];
  logic              ng  [0:FB][0:LANES-1];
  logic [LANES-1:0][CW-1:0] ent;

  assign adv     = !out_valid || !out_stall;
  assign job_pop = adv && !job_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= FB; s++) v[s] <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v[0] <= !job_empty;
      for (int s = 1; s <= FB; s++) v[s] <= v[s-1];
      out_valid <= v[FB];
    end
  end

  // entry stage: magnitude and integer quotient bit
  always_ff @(posedge clk) begin
    logic [MW-1:0] a;
    logic          ge;
    if (adv) begin
      dn[0] <= job.n;
      zf[0] <= job.zero;
      for (int l = 0; l < LANES; l++) begin
        a  = job.num[l][MW-1] ? -job.num[l] : job.num[l];
        ge = (a[NW-1:0] >= job.n);
        ng[0][l]  <= job.num[l][MW-1];
        rem[0][l] <= ge ? a[NW-1:0] - job.n : a[NW-1:0];
        quo[0][l] <= QW'(ge);
      end
    end
  end

  // one fraction bit per stage
  always_ff @(posedge clk) begin
    logic [NW:0] sh;
    logic        ge;
    if (adv) begin
      for (int s = 1; s <= FB; s++) begin
        dn[s] <= dn[s-1];
        zf[s] <= zf[s-1];
        for (int l = 0; l < LANES; l++) begin
          sh = {rem[s-1][l], 1'b0};
          ge = (sh >= {1'b0, dn[s-1]});
          ng[s][l]  <= ng[s-1][l];
          rem[s][l] <= ge ? NW'(sh - {1'b0, dn[s-1]}) : NW'(sh);
          quo[s][l] <= {quo[s-1][l][QW-2:0], ge};
        end
      end
    end
  end

  always_comb begin
    logic [SW-1:0] q;
    for (int l = 0; l < LANES; l++) begin
      q = SW'(quo[FB][l]);
      if (zf[FB])          ent[l] = '0;
      else if (!ng[FB][l]) ent[l] = (q > MAXPOS) ? MAXPOS[CW-1:0] : q[CW-1:0];
      else                 ent[l] = (q > MAXNEG) ? MAXNEG[CW-1:0] : CW'(-q);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.r0c0      <= ent[0];
      out_data.r1c0      <= ent[1];
      out_data.r2c0      <= ent[2];
      out_data.r0c1      <= ent[3];
      out_data.r1c1      <= ent[4];
      out_data.r2c1      <= ent[5];
      out_data.r0c2      <= ent[6];
      out_data.r1c2      <= ent[7];
      out_data.r2c2      <= ent[8];
      out_data.zero_norm <= zf[FB];
    end
  end

  a_zero_entries: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.zero_norm) |->
      (out_data.r0c0 == '0 && out_data.r1c1 == '0 && out_data.r2c2 == '0))
    else $error("zero norm beat carries non-zero entries");
  a_pop_moves: assert property (@(posedge clk) disable iff (rst)
    job_pop |=> v[0]) else $error("popped job not in pipeline");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("stalled result dropped");

endmodule

FILE: tb/tb.sv
// Testbench for the quaternion to rotation matrix block: table-driven and random beats.
module tb;
  import qtrm_pkg::*;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  qtrm_in_t  in_data;
  logic      out_valid;
  logic      out_stall;
  qtrm_out_t out_data;

  quaternion_to_rotation_matrix DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  localparam int LATENCY    = 20;
  localparam int CYCLE_CAP  = 400000;
  localparam int N_RANDOM   = 1800;
  localparam logic signed [CW-1:0] ONE = 16'sd16384;
  localparam logic signed [CW-1:0] NEG_ONE = -16'sd16384;

  typedef struct {
    qtrm_in_t  q;
    bit        known;
    qtrm_out_t m;
  } dir_row_t;

  qtrm_out_t matrix_q[$];
  int        errors;
  int        cycles;
  bit        long_hold;
  bit        hold_done;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // (num/n) * 2^FB, truncated toward zero, saturated; num is signed, n > 0
  function automatic logic signed [CW-1:0] ratio_q14(longint num, longint n);
    longint mag;
    longint q;
    bit     neg;
    neg = num < 0;
    mag = neg ? -num : num;
    q = (mag << FB) / n;
    if (!neg) return (q > 32767) ? 16'sd32767 : CW'(q);
    if (q > 32768) q = 32768;
    return CW'(-q);
  endfunction

  function automatic qtrm_out_t rotation_of(qtrm_in_t q);
    qtrm_out_t m;
    longint w, x, y, z, n;
    w = q.quat_w; x = q.quat_x; y = q.quat_y; z = q.quat_z;
    n = w*w + x*x + y*y + z*z;
    m = '0;
    if (n == 0) begin
      m.zero_norm = 1'b1;
      return m;
    end
    m.r0c0 = ratio_q14(n - 2*(y*y + z*z), n);
    m.r1c0 = ratio_q14(2*(x*y + w*z), n);
    m.r2c0 = ratio_q14(2*(x*z - w*y), n);
    m.r0c1 = ratio_q14(2*(x*y - w*z), n);
    m.r1c1 = ratio_q14(n - 2*(x*x + z*z), n);
    m.r2c1 = ratio_q14(2*(y*z + w*x), n);
    m.r0c2 = ratio_q14(2*(x*z + w*y), n);
    m.r1c2 = ratio_q14(2*(y*z - w*x), n);
    m.r2c2 = ratio_q14(n - 2*(x*x + y*y), n);
    return m;
  endfunction

  function automatic qtrm_out_t diag(logic signed [CW-1:0] a, b, c);
    qtrm_out_t m;
    m = '0;
    m.r0c0 = a; m.r1c1 = b; m.r2c2 = c;
    return m;
  endfunction

  function automatic qtrm_in_t quat(int w, int x, int y, int z);
    qtrm_in_t q;
    q.quat_w = CW'(w); q.quat_x = CW'(x); q.quat_y = CW'(y); q.quat_z = CW'(z);
    return q;
  endfunction

  function automatic qtrm_in_t random_quat();
    qtrm_in_t q;
    int k;
    q = {$urandom(), $urandom()};
    k = $urandom_range(0, 9);
    // small magnitudes now and then, and single-axis beats
    if (k == 0) q = quat($urandom_range(0, 6) - 3, $urandom_range(0, 6) - 3,
                         $urandom_range(0, 6) - 3, $urandom_range(0, 6) - 3);
    else if (k == 1) q.quat_x = '0;
    else if (k == 2) begin q.quat_y = '0; q.quat_z = '0; end
    return q;
  endfunction

  task automatic send_beat(qtrm_in_t q);
    in_data  <= q;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    matrix_q.push_back(rotation_of(q));
  endtask

  task automatic idle_gap();
    int g;
    g = $urandom_range(0, 10);
    if ($urandom_range(0, 3) == 0) g = 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // sender
  initial begin
    dir_row_t rows[$];
    dir_row_t r;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    long_hold = 1'b0;
    rows.push_back('{quat(0, 0, 0, 0), 1, '{zero_norm: 1'b1, default: '0}});
    rows.push_back('{quat(16384, 0, 0, 0), 1, diag(ONE, ONE, ONE)});
    rows.push_back('{quat(-16384, 0, 0, 0), 1, diag(ONE, ONE, ONE)});
    rows.push_back('{quat(0, 16384, 0, 0), 1, diag(ONE, NEG_ONE, NEG_ONE)});
    rows.push_back('{quat(0, 0, 16384, 0), 1, diag(NEG_ONE, ONE, NEG_ONE)});
    rows.push_back('{quat(0, 0, 0, 16384), 1, diag(NEG_ONE, NEG_ONE, ONE)});
    rows.push_back('{quat(-32768, 0, 0, 0), 1, diag(ONE, ONE, ONE)});
    rows.push_back('{quat(1, 0, 0, 0), 1, diag(ONE, ONE, ONE)});
    rows.push_back('{quat(0, -1, 0, 0), 1, diag(ONE, NEG_ONE, NEG_ONE)});
    rows.push_back('{quat(32767, 32767, 32767, 32767), 0, '0});
    rows.push_back('{quat(-32768, -32768, -32768, -32768), 0, '0});
    rows.push_back('{quat(-32768, 32767, -32768, 32767), 0, '0});
    rows.push_back('{quat(11585, 11585, 0, 0), 0, '0});
    rows.push_back('{quat(8192, 8192, 8192, 8192), 0, '0});
    rows.push_back('{quat(3, -7, 5, 1), 0, '0});
    rows.push_back('{quat(-1, 1, -1, 1), 0, '0});
    rows.push_back('{quat(0, 32767, -32768, 0), 0, '0});
    rows.push_back('{quat(16384, 0, 0, 0), 0, '0});
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[i]) begin
      r = rows[i];
      if (r.known && r.m !== rotation_of(r.q))
        $error("table row %0d disagrees with predictor", i);
      send_beat(r.q);
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 300) long_hold = 1'b1;
      if (i == 900) begin
        // let the pipe drain before carrying on
        in_valid <= 1'b0;
        @(posedge clk);
        while (matrix_q.size() != 0) @(posedge clk);
      end
      if (i > 200 && i < 260) begin
        send_beat(random_quat());
      end else begin
        idle_gap();
        send_beat(random_quat());
      end
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (matrix_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  // receiver stall pattern
  initial begin
    int g;
    out_stall = 1'b0;
    hold_done = 1'b0;
    @(negedge rst);
    forever begin
      if (long_hold && !hold_done) begin
        // long enough for the sender to fill every stage and the queue
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
      end
      g = $urandom_range(0, 10);
      if ($urandom_range(0, 3) == 0) g = 0;
      if (g > 0) begin
        out_stall <= 1'b1;
        repeat (g) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // result checker
  always @(posedge clk) begin
    qtrm_out_t e;
    if (!rst && out_valid && !out_stall) begin
      if (matrix_q.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        e = matrix_q.pop_front();
        if (out_data.r0c0 !== e.r0c0) begin
          $error("r0c0 exp %0d got %0d", e.r0c0, out_data.r0c0); errors++; end
        if (out_data.r1c0 !== e.r1c0) begin
          $error("r1c0 exp %0d got %0d", e.r1c0, out_data.r1c0); errors++; end
        if (out_data.r2c0 !== e.r2c0) begin
          $error("r2c0 exp %0d got %0d", e.r2c0, out_data.r2c0); errors++; end
        if (out_data.r0c1 !== e.r0c1) begin
          $error("r0c1 exp %0d got %0d", e.r0c1, out_data.r0c1); errors++; end
        if (out_data.r1c1 !== e.r1c1) begin
          $error("r1c1 exp %0d got %0d", e.r1c1, out_data.r1c1); errors++; end
        if (out_data.r2c1 !== e.r2c1) begin
          $error("r2c1 exp %0d got %0d", e.r2c1, out_data.r2c1); errors++; end
        if (out_data.r0c2 !== e.r0c2) begin
          $error("r0c2 exp %0d got %0d", e.r0c2, out_data.r0c2); errors++; end
        if (out_data.r1c2 !== e.r1c2) begin
          $error("r1c2 exp %0d got %0d", e.r1c2, out_data.r1c2); errors++; end
        if (out_data.r2c2 !== e.r2c2) begin
          $error("r2c2 exp %0d got %0d", e.r2c2, out_data.r2c2); errors++; end
        if (out_data.zero_norm !== e.zero_norm) begin
          $error("zero_norm exp %0b got %0b", e.zero_norm, out_data.zero_norm);
          errors++;
        end
      end
    end
  end

  initial begin
    errors = 0;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_CAP) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

endmodule
